### sv/vision_target_angle_reference_top_macros.svh
// ----------------------------------------------------------------------------
// Vision target angle reference assertion macros
// Short forms for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef VISION_TARGET_ANGLE_REFERENCE_TOP_MACROS_SVH
`define VISION_TARGET_ANGLE_REFERENCE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define VTAR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define VTAR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/vtar_pkg.sv
// ----------------------------------------------------------------------------
// Vision target angle reference package
// Shared constants, register codes, item and config types, CORDIC table.
// ----------------------------------------------------------------------------
package vtar_pkg;

	localparam int IMAGE_WIDTH_DEF  = 1280;
	localparam int IMAGE_HEIGHT_DEF = 720;

	localparam int CORDIC_STEPS   = 20;
	localparam int PI_Q20         = 3294199;
	localparam int HALF_PI_Q20    = 1647099;
	localparam int KINV_Q30       = 652032874;
	localparam int DEAD_PITCH_Q17 = 2621;

	// datapath widths: rotation, vector magnitude, vectoring lanes
	localparam int CW = 33;
	localparam int AW = 52;
	localparam int LW = 44;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPW         = $clog2(QUEUE_DEPTH);

	localparam int IN_W   = 64;
	localparam int OUT_W  = 88;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 26;

	typedef enum logic [CIDX_W-1:0] {
		REG_FILTER_KEEP   = 3'd0,
		REG_ROLL_DEADZONE = 3'd1,
		REG_ROLL_CLAMP    = 3'd2,
		REG_PITCH_CLAMP   = 3'd3,
		REG_PIXEL_PITCH_X = 3'd4,
		REG_PIXEL_PITCH_Y = 3'd5,
		REG_LENS_FOCAL    = 3'd6
	} vtar_reg_t;

	typedef struct packed {
		logic [15:0] filter_keep;
		logic [15:0] roll_deadzone;
		logic [18:0] roll_clamp;
		logic [18:0] pitch_clamp;
		logic [15:0] pixel_pitch_x;
		logic [15:0] pixel_pitch_y;
		logic [25:0] lens_focal;
	} vtar_cfg_t;

	// one classified item waiting for the back end
	typedef struct packed {
		logic signed [13:0] u2;
		logic signed [13:0] v2;
		logic signed [19:0] roll;
		logic [31:0]        num;
		logic               neg;
		logic               spd_en;
		logic [15:0]        dt;
	} vtar_job_t;

	function automatic logic [19:0] vtar_atan(input logic [4:0] i);
		logic [19:0] r;
		begin
			unique case (i)
				5'd0:  r = 20'd823550;
				5'd1:  r = 20'd486170;
				5'd2:  r = 20'd256879;
				5'd3:  r = 20'd130396;
				5'd4:  r = 20'd65451;
				5'd5:  r = 20'd32757;
				5'd6:  r = 20'd16383;
				5'd7:  r = 20'd8192;
				5'd8:  r = 20'd4096;
				5'd9:  r = 20'd2048;
				5'd10: r = 20'd1024;
				5'd11: r = 20'd512;
				5'd12: r = 20'd256;
				5'd13: r = 20'd128;
				5'd14: r = 20'd64;
				5'd15: r = 20'd32;
				5'd16: r = 20'd16;
				5'd17: r = 20'd8;
				5'd18: r = 20'd4;
				5'd19: r = 20'd2;
				default: r = 20'd0;
			endcase
			return r;
		end
	endfunction

endpackage

### sv/vision_target_angle_reference_top.sv
// ----------------------------------------------------------------------------
// Vision target angle reference top level
// Roll and pitch line-of-sight references and column speed per detection.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one detection per item; m_* returns one result item per
//   detection, in order. cfg_* writes a register by index at any time the
//   block is idle; cfg_ready is always high and unknown indexes are dropped.
//   Each item runs through the single back-end sequencer: 20 sine/cosine
//   CORDIC steps, up to 16 normalizing shifts, 3 squares, 32 square-root
//   steps, 20 atan2 CORDIC steps in two lanes and the filter. The column
//   speed divide runs beside it. One item is worked on at a time; the
//   sequencer takes the next item only once the last result has gone
//   into the output register.
//   A two-entry queue in front of the sequencer keeps accepting detections
//   while a result waits in the output register; when the receiver stalls,
//   the result holds and the sequencer waits before it updates its filter.
//   Reset clears the filter state, the previous column and all queues, and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module vision_target_angle_reference_top #(
	parameter int IMAGE_WIDTH  = vtar_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = vtar_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// column[11:0], row[23:12], roll_now[43:24], elapsed_us[59:44], zero pad
	input  logic [vtar_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// roll_reference[19:0], pitch_reference[39:20], roll_filtered[59:40],
	// column_speed[83:60], zero pad
	output logic [vtar_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vtar_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [vtar_pkg::CDAT_W-1:0]  cfg_data
);
	import vtar_pkg::*;

	vtar_cfg_t cfg_q;
	vtar_job_t fr_job, q_job;
	logic      q_full, push, q_valid, pop;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_keep   <= 16'd52429;
			cfg_q.roll_deadzone <= 16'd137;
			cfg_q.roll_clamp    <= 19'd68629;
			cfg_q.pitch_clamp   <= 19'd68629;
			cfg_q.pixel_pitch_x <= 16'd3000;
			cfg_q.pixel_pitch_y <= 16'd3000;
			cfg_q.lens_focal    <= 26'd4000000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FILTER_KEEP:   cfg_q.filter_keep   <= cfg_data[15:0];
				REG_ROLL_DEADZONE: cfg_q.roll_deadzone <= cfg_data[15:0];
				REG_ROLL_CLAMP:    cfg_q.roll_clamp    <= cfg_data[18:0];
				REG_PITCH_CLAMP:   cfg_q.pitch_clamp   <= cfg_data[18:0];
				REG_PIXEL_PITCH_X: cfg_q.pixel_pitch_x <= cfg_data[15:0];
				REG_PIXEL_PITCH_Y: cfg_q.pixel_pitch_y <= cfg_data[15:0];
				REG_LENS_FOCAL:    cfg_q.lens_focal    <= cfg_data;
				default: ;
			endcase
		end
	end

	vtar_front #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.job      (fr_job)
	);

	vtar_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (fr_job),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_job   (q_job)
	);

	vtar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (q_valid),
		.job       (q_job),
		.job_pop   (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

### sv/vtar_front.sv
// ----------------------------------------------------------------------------
// Vision target angle reference front end
// Accepts detections, forms centre offsets and the speed numerator.
// ----------------------------------------------------------------------------
module vtar_front #(
	parameter int IMAGE_WIDTH  = 1280,
	parameter int IMAGE_HEIGHT = 720
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [vtar_pkg::IN_W-1:0] s_tdata,
	input  logic                     q_full,
	output logic                     push,
	output vtar_pkg::vtar_job_t      job
);
	import vtar_pkg::*;

	localparam logic signed [13:0] UOFF = 14'(IMAGE_WIDTH + 1);
	localparam logic signed [13:0] VOFF = 14'(IMAGE_HEIGHT + 1);

	logic [11:0] column, row, last_column_q, mag;
	logic [15:0] elapsed_us;
	logic        have_last_q;
	logic [12:0] dcol, dneg;

	assign column     = s_tdata[11:0];
	assign row        = s_tdata[23:12];
	assign elapsed_us = s_tdata[59:44];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// classify: offsets, column step magnitude and speed enable
	assign dcol = {1'b0, column} - {1'b0, last_column_q};
	assign dneg = -dcol;
	assign mag  = dcol[12] ? dneg[11:0] : dcol[11:0];

	always_comb begin
		job.u2     = $signed({1'b0, column, 1'b0}) - UOFF;
		job.v2     = $signed({1'b0, row, 1'b0}) - VOFF;
		job.roll   = $signed(s_tdata[43:24]);
		job.num    = 32'(mag) * 32'd1000000;
		job.neg    = dcol[12];
		job.spd_en = have_last_q && (elapsed_us >= 16'd2);
		job.dt     = elapsed_us;
	end

	// remember the column of the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_column_q <= '0;
			have_last_q   <= 1'b0;
		end else if (push) begin
			last_column_q <= column;
			have_last_q   <= 1'b1;
		end
	end

endmodule

### sv/vtar_queue.sv
// ----------------------------------------------------------------------------
// Vision target angle reference item queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module vtar_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vtar_pkg::vtar_job_t wr_job,
	output logic                full,
	input  logic                pop,
	output logic                rd_valid,
	output vtar_pkg::vtar_job_t rd_job
);
	import vtar_pkg::*;

	vtar_job_t      mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPW:0]   count_q;

	assign full     = (count_q == (QPW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];

	// store item
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### sv/vtar_back.sv
// ----------------------------------------------------------------------------
// Vision target angle reference back end
// Sequencer for derotation, norm, atan2, low-pass, clamp and speed divide.
// ----------------------------------------------------------------------------
module vtar_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vtar_pkg::vtar_cfg_t        cfg,
	input  logic                       job_valid,
	input  vtar_pkg::vtar_job_t        job,
	output logic                       job_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [vtar_pkg::OUT_W-1:0] out_data
);
	import vtar_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROT, ST_M1, ST_M2, ST_M3, ST_M4, ST_ABS, ST_NORM,
		ST_SQ, ST_SQRT, ST_GUARD, ST_ATAN, ST_F1, ST_F2, ST_FIN
	} state_t;

	state_t state_q;
	logic [4:0] step_q;

	logic signed [13:0]   u2_q, v2_q;
	logic signed [23:0]   ang_q;
	logic                 flip_q;
	logic signed [CW-1:0] cx_q, sy_q;
	logic signed [47:0]   puc_q, pvs_q;
	logic signed [35:0]   xq_q;
	logic signed [AW-1:0] xv_q, yv_q;
	logic [AW-1:0]        ax_q, ay_q, az_q;
	logic                 xneg_q, yneg_q;
	logic [62:0]          acc_q, rv_q, rr_q, rb_q;
	logic signed [LW-1:0] xr_q, yr_q, xp_q, yp_q;
	logic signed [23:0]   zr_q, zp_q;
	logic signed [19:0]   cam_r_q, cam_p_q;
	logic signed [41:0]   pk_r_q, pk_p_q;
	logic signed [42:0]   ac_r_q, ac_p_q;
	logic signed [23:0]   roll_state_q, pitch_state_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	// speed divider
	logic [31:0] dnum_q, dquo_q;
	logic [15:0] drem_q, ddt_q;
	logic [5:0]  dcnt_q;
	logic        dneg_q, den_q;
	logic [16:0] drsh;

	logic slot_free;
	assign slot_free = !out_valid_q || out_ready;
	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// angle entry: roll in Q.20, moved by pi when beyond a quarter turn
	logic signed [23:0] ang_in;
	logic signed [23:0] ang_red;
	logic               flip_in;
	always_comb begin
		ang_in  = {job.roll[19], job.roll, 3'b000};
		flip_in = 1'b0;
		ang_red = ang_in;
		if (ang_in > 24'sd1647099) begin
			ang_red = ang_in - 24'sd3294199;
			flip_in = 1'b1;
		end else if (ang_in < -24'sd1647099) begin
			ang_red = ang_in + 24'sd3294199;
			flip_in = 1'b1;
		end
	end

	// rotation step terms
	logic signed [CW-1:0] rx_sh, ry_sh, cf, sf;
	logic signed [23:0]   atn;
	assign rx_sh = cx_q >>> step_q;
	assign ry_sh = sy_q >>> step_q;
	assign atn   = $signed({4'b0, vtar_atan(step_q)});
	assign cf    = flip_q ? -cx_q : cx_q;
	assign sf    = flip_q ? -sy_q : sy_q;

	// squares and root terms
	logic [29:0] sq_op;
	logic [59:0] sq;
	logic [62:0] rt;
	always_comb begin
		case (step_q)
			5'd0:    sq_op = ax_q[29:0];
			5'd1:    sq_op = ay_q[29:0];
			default: sq_op = az_q[29:0];
		endcase
	end
	assign sq = 60'(sq_op) * 60'(sq_op);
	assign rt = rr_q + rb_q;

	// guard on the forward component
	logic [39:0] az1k, ax1k, ay1k, nxm, nym;
	logic        guard;
	assign az1k  = 40'(az_q[29:0]) * 40'd1000;
	assign ax1k  = 40'(ax_q[29:0]) * 40'd1000;
	assign ay1k  = 40'(ay_q[29:0]) * 40'd1000;
	assign guard = {23'b0, az1k} < rr_q;
	assign nxm   = guard ? ax1k : 40'(ax_q[29:0]);
	assign nym   = guard ? ay1k : 40'(ay_q[29:0]);

	// vectoring lane terms
	logic signed [LW-1:0] xr_sh, yr_sh, xp_sh, yp_sh;
	assign xr_sh = xr_q >>> step_q;
	assign yr_sh = yr_q >>> step_q;
	assign xp_sh = xp_q >>> step_q;
	assign yp_sh = yp_q >>> step_q;

	// filter weights
	logic signed [16:0] kw;
	logic signed [17:0] kc;
	assign kw = $signed({1'b0, cfg.filter_keep});
	assign kc = 18'sd65536 - 18'($signed({1'b0, cfg.filter_keep}));

	// filter output, deadzone and clamp
	logic signed [23:0] ns_r, ns_p, st_r, st_p;
	logic signed [24:0] ab_r, ab_p, lim_r, lim_p, neg_p, rref, pref;
	always_comb begin
		ns_r  = 24'((ac_r_q + 43'sd32768) >>> 16);
		ns_p  = 24'((ac_p_q + 43'sd32768) >>> 16);
		ab_r  = ns_r[23] ? -25'(ns_r) : 25'(ns_r);
		ab_p  = ns_p[23] ? -25'(ns_p) : 25'(ns_p);
		st_r  = (ab_r < $signed({9'b0, cfg.roll_deadzone})) ? 24'sd0 : ns_r;
		st_p  = (ab_p <= 25'sd2621) ? 24'sd0 : ns_p;
		lim_r = $signed({6'b0, cfg.roll_clamp});
		lim_p = $signed({6'b0, cfg.pitch_clamp});
		neg_p = -25'(st_p);
		if (25'(st_r) > lim_r)
			rref = lim_r;
		else if (25'(st_r) < -lim_r)
			rref = -lim_r;
		else
			rref = 25'(st_r);
		if (neg_p > lim_p)
			pref = lim_p;
		else if (neg_p < -lim_p)
			pref = -lim_p;
		else
			pref = neg_p;
	end

	// speed saturation
	logic [23:0] speed, qneg;
	assign qneg = -dquo_q[23:0];
	always_comb begin
		if (!den_q)
			speed = '0;
		else if (!dneg_q)
			speed = (dquo_q > 32'd8388607) ? 24'h7FFFFF : dquo_q[23:0];
		else
			speed = (dquo_q > 32'd8388608) ? 24'h800000 : qneg;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			roll_state_q  <= '0;
			pitch_state_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// raise on a finished item, drop once the result is taken
			if (state_q == ST_FIN && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						u2_q    <= job.u2;
						v2_q    <= job.v2;
						ang_q   <= ang_red;
						flip_q  <= flip_in;
						cx_q    <= CW'(KINV_Q30);
						sy_q    <= '0;
						step_q  <= '0;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (ang_q >= 0) begin
						cx_q  <= cx_q - ry_sh;
						sy_q  <= sy_q + rx_sh;
						ang_q <= ang_q - atn;
					end else begin
						cx_q  <= cx_q + ry_sh;
						sy_q  <= sy_q - rx_sh;
						ang_q <= ang_q + atn;
					end
					if (step_q == 5'(CORDIC_STEPS - 1))
						state_q <= ST_M1;
					else
						step_q <= step_q + 1'b1;
				end
				ST_M1: begin
					puc_q   <= 48'(u2_q) * 48'(cf);
					state_q <= ST_M2;
				end
				ST_M2: begin
					pvs_q   <= 48'(v2_q) * 48'(sf);
					state_q <= ST_M3;
				end
				ST_M3: begin
					xq_q    <= 36'((puc_q + pvs_q) >>> 14);
					yv_q    <= (AW'(v2_q) * AW'($signed({1'b0, cfg.pixel_pitch_y}))) <<< 16;
					state_q <= ST_M4;
				end
				ST_M4: begin
					xv_q    <= AW'(xq_q) * AW'($signed({1'b0, cfg.pixel_pitch_x}));
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					ax_q    <= xv_q[AW-1] ? AW'(-xv_q) : AW'(xv_q);
					ay_q    <= yv_q[AW-1] ? AW'(-yv_q) : AW'(yv_q);
					az_q    <= AW'({cfg.lens_focal, 17'b0});
					xneg_q  <= xv_q[AW-1];
					yneg_q  <= yv_q[AW-1];
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					// shift all three down until each fits in 30 bits
					if (|(ax_q[AW-1:30] | ay_q[AW-1:30] | az_q[AW-1:30])) begin
						ax_q <= ax_q >> 1;
						ay_q <= ay_q >> 1;
						az_q <= az_q >> 1;
					end else begin
						acc_q   <= '0;
						step_q  <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (step_q == 5'd2) begin
						rv_q    <= acc_q + 63'(sq);
						rr_q    <= '0;
						rb_q    <= 63'(1) << 62;
						step_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						acc_q  <= acc_q + 63'(sq);
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (rv_q >= rt) begin
						rv_q <= rv_q - rt;
						rr_q <= (rr_q >> 1) + rb_q;
					end else begin
						rr_q <= rr_q >> 1;
					end
					rb_q <= rb_q >> 2;
					if (step_q == 5'd31)
						state_q <= ST_GUARD;
					else
						step_q <= step_q + 1'b1;
				end
				ST_GUARD: begin
					xr_q    <= guard ? $signed(LW'(rr_q[31:0])) : $signed(LW'(az_q[29:0]));
					xp_q    <= guard ? $signed(LW'(rr_q[31:0])) : $signed(LW'(az_q[29:0]));
					yr_q    <= xneg_q ? -$signed({4'b0, nxm}) : $signed({4'b0, nxm});
					yp_q    <= yneg_q ? -$signed({4'b0, nym}) : $signed({4'b0, nym});
					zr_q    <= '0;
					zp_q    <= '0;
					step_q  <= '0;
					state_q <= ST_ATAN;
				end
				ST_ATAN: begin
					if (yr_q >= 0) begin
						xr_q <= xr_q + yr_sh;
						yr_q <= yr_q - xr_sh;
						zr_q <= zr_q + atn;
					end else begin
						xr_q <= xr_q - yr_sh;
						yr_q <= yr_q + xr_sh;
						zr_q <= zr_q - atn;
					end
					if (yp_q >= 0) begin
						xp_q <= xp_q + yp_sh;
						yp_q <= yp_q - xp_sh;
						zp_q <= zp_q + atn;
					end else begin
						xp_q <= xp_q - yp_sh;
						yp_q <= yp_q + xp_sh;
						zp_q <= zp_q - atn;
					end
					if (step_q == 5'(CORDIC_STEPS - 1))
						state_q <= ST_F1;
					else
						step_q <= step_q + 1'b1;
				end
				ST_F1: begin
					cam_r_q <= 20'((zr_q + 24'sd4) >>> 3);
					cam_p_q <= 20'((zp_q + 24'sd4) >>> 3);
					pk_r_q  <= 42'(roll_state_q) * 42'(kw);
					pk_p_q  <= 42'(pitch_state_q) * 42'(kw);
					state_q <= ST_F2;
				end
				ST_F2: begin
					ac_r_q  <= 43'(pk_r_q) + 43'(cam_r_q) * 43'(kc);
					ac_p_q  <= 43'(pk_p_q) + 43'(cam_p_q) * 43'(kc);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register is free
					if (slot_free) begin
						roll_state_q  <= st_r;
						pitch_state_q <= st_p;
						out_data_q    <= {4'b0, speed, st_r[19:0], pref[19:0], rref[19:0]};
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring divide for the column speed, one quotient bit a cycle
	assign drsh = {drem_q, dnum_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (job_pop) begin
			dnum_q <= job.num;
			ddt_q  <= job.dt;
			dneg_q <= job.neg;
			den_q  <= job.spd_en;
			drem_q <= '0;
			dquo_q <= '0;
			dcnt_q <= 6'd32;
		end else if (dcnt_q != '0) begin
			dnum_q <= dnum_q << 1;
			if (drsh >= {1'b0, ddt_q}) begin
				drem_q <= 16'(drsh - {1'b0, ddt_q});
				dquo_q <= {dquo_q[30:0], 1'b1};
			end else begin
				drem_q <= drsh[15:0];
				dquo_q <= {dquo_q[30:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

endmodule

### sv/vtar_checker.sv
// ----------------------------------------------------------------------------
// Vision target angle reference port checker
// Tracks items in flight and checks results and stalls against the ports.
// ----------------------------------------------------------------------------
`include "vision_target_angle_reference_top_macros.svh"

module vtar_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [vtar_pkg::OUT_W-1:0] m_tdata
);
	logic [2:0] pend_q;

	// count items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
			pend_q <= pend_q + 1'b1;
		else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready))
			pend_q <= pend_q - 1'b1;
	end

	`VTAR_ASSERT_IMP(a_no_orphan, m_tvalid, pend_q != 3'd0, "result with no item in flight")
	`VTAR_ASSERT_IMP(a_pend_max, 1'b1, pend_q <= 3'd4, "more items in flight than storage")
	`VTAR_ASSERT_IMP(a_full_stall, pend_q == 3'd4, !s_tready, "input taken with storage full")
	`VTAR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind vision_target_angle_reference_top vtar_checker u_vtar_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
